### rtl/core/pwm_slot_attach_router_macros.svh
// Assertion macros for the PWM slot attach router.
// Included by the top level; assertions vanish when SYNTHESIS is defined.
`ifndef PWM_SLOT_ATTACH_ROUTER_MACROS_SVH
`define PWM_SLOT_ATTACH_ROUTER_MACROS_SVH

`ifndef SYNTHESIS
// Property that must hold on every clock edge outside reset.
`define PSAR_ASSERT(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("pwm_slot_attach_router: check failed");
// Antecedent implies consequent in the same cycle.
`define PSAR_IMPLIES(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("pwm_slot_attach_router: implication failed");
`else
`define PSAR_ASSERT(label, clk, rstn, prop)
`define PSAR_IMPLIES(label, clk, rstn, ante, cons)
`endif

`endif

### rtl/core/pwm_sar_pkg.sv
// Shared types and constants for the PWM slot attach router.
// No dependencies.
package pwm_sar_pkg;

    localparam int DUTY_OUT_W = 10;

    localparam logic [1:0] ACT_IGNORED = 2'd0;
    localparam logic [1:0] ACT_LEVEL   = 2'd1;
    localparam logic [1:0] ACT_PWM     = 2'd2;

    localparam logic [6:0] PCT_MAX = 7'd100;

    typedef struct packed {
        logic       func;
        logic [3:0] channel;
        logic       level_on;
        logic [7:0] duty_percent;
    } cmd_t;

    typedef struct packed {
        logic [1:0]            action;
        logic [3:0]            out_channel;
        logic [2:0]            pwm_slot;
        logic                  newly_bound;
        logic                  level;
        logic [DUTY_OUT_W-1:0] duty;
    } result_t;

endpackage

### rtl/core/pwm_sar_ram.sv
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
module pwm_sar_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    clk,
    we,
    waddr,
    wdata,
    raddr,
    rdata
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    input  logic             clk;
    input  logic             we;
    input  logic [AW-1:0]    waddr;
    input  logic [WIDTH-1:0] wdata;
    input  logic [AW-1:0]    raddr;
    output logic [WIDTH-1:0] rdata;

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### rtl/core/pwm_slot_attach_router.sv
// PWM slot attach router.
// Command start/busy in, one result per command out with a done strobe.
// Uses the channel binding memory (pwm_sar_ram) and the shared package.
//
// Assert start with a command on cmd while busy is low; the command is taken
// at that edge. The binding memory is read in that same cycle and the command
// is resolved in the next one, when busy is high. The result appears on result
// with done high for exactly one cycle, the cycle after busy; busy has fallen
// by then, so a new command may be taken in the same cycle that done is shown.
// A new command is not taken while the last one is being resolved: the binding
// memory read data is registered ahead of the read-modify-write.
// A dimming command for an unbound channel takes the next free slot (slots are
// never released, so this is the slot count); with the pool exhausted the
// channel is driven plainly on. Channels at or above NUM_OUTPUTS are ignored.
// Reset clears the per-channel bound flags and the slot count at once; the
// memory needs no clearing pass, entries are only read behind a set flag.
// The receiver cannot stall: done is not held, results are not buffered.
module pwm_slot_attach_router #(
    parameter int NUM_OUTPUTS   = 12,
    parameter int NUM_PWM_SLOTS = 8,
    parameter int DUTY_BITS     = 10
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  pwm_sar_pkg::cmd_t     cmd,
    output logic                  done,
    output pwm_sar_pkg::result_t  result
);
    import pwm_sar_pkg::*;

`include "pwm_slot_attach_router_macros.svh"

    localparam int CH_AW    = (NUM_OUTPUTS > 1) ? $clog2(NUM_OUTPUTS) : 1;
    localparam int SLOT_W   = (NUM_PWM_SLOTS > 1) ? $clog2(NUM_PWM_SLOTS) : 1;
    localparam int CNT_W    = $clog2(NUM_PWM_SLOTS + 1);
    localparam int unsigned DUTY_FULL = (32'd1 << DUTY_BITS) - 32'd1;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    logic                 state_reg, state_next;
    cmd_t                 cmd_reg;
    logic [NUM_OUTPUTS-1:0] bound_reg, bound_next;
    logic [CNT_W-1:0]     slots_used_reg, slots_used_next;
    logic                 done_reg;
    result_t              result_reg, result_next;

    logic                 accept;
    logic                 bind_we;
    logic [SLOT_W-1:0]    bind_rdata;
    logic [SLOT_W-1:0]    new_slot;
    logic [CH_AW-1:0]     ch_idx;
    logic                 in_range;
    logic                 is_bound;
    logic                 pool_free;
    logic [6:0]           pct_c;

    // Percent to duty, worked out at elaboration
    logic [DUTY_OUT_W-1:0] duty_lut [101];

    for (genvar g = 0; g <= 100; g++)
    begin : g_duty
        localparam int unsigned VAL = (DUTY_FULL * g) / 100;
        assign duty_lut[g] = DUTY_OUT_W'(VAL);
    end

    assign accept = start && (state_reg == ST_IDLE);
    assign busy   = (state_reg == ST_EXEC);
    assign done   = done_reg;
    assign result = result_reg;

    assign ch_idx    = cmd_reg.channel[CH_AW-1:0];
    assign in_range  = ({1'b0, cmd_reg.channel} < 5'(NUM_OUTPUTS));
    assign is_bound  = in_range && bound_reg[ch_idx];
    assign pool_free = (slots_used_reg < CNT_W'(NUM_PWM_SLOTS));
    assign new_slot  = slots_used_reg[SLOT_W-1:0];
    assign pct_c     = (cmd_reg.duty_percent > {1'b0, PCT_MAX}) ? PCT_MAX
                                                                : cmd_reg.duty_percent[6:0];

    pwm_sar_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (NUM_OUTPUTS)
    ) u_bind_ram (
        .clk   (clk),
        .we    (bind_we),
        .waddr (ch_idx),
        .wdata (new_slot),
        .raddr (cmd.channel[CH_AW-1:0]),
        .rdata (bind_rdata)
    );

    always_comb
    begin
        state_next      = state_reg;
        bound_next      = bound_reg;
        slots_used_next = slots_used_reg;
        bind_we         = 1'b0;
        result_next     = '0;
        result_next.out_channel = cmd_reg.channel;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = ST_IDLE;
                if (in_range)
                begin
                    if (!cmd_reg.func)
                    begin
                        if (is_bound)
                        begin
                            result_next.action   = ACT_PWM;
                            result_next.pwm_slot = 3'(bind_rdata);
                            result_next.duty     = cmd_reg.level_on ? DUTY_OUT_W'(DUTY_FULL)
                                                                    : '0;
                        end
                        else
                        begin
                            result_next.action = ACT_LEVEL;
                            result_next.level  = cmd_reg.level_on;
                        end
                    end
                    else if (is_bound)
                    begin
                        result_next.action   = ACT_PWM;
                        result_next.pwm_slot = 3'(bind_rdata);
                        result_next.duty     = duty_lut[pct_c];
                    end
                    else if (pool_free)
                    begin
                        // first dimming transfer for this channel: take the next slot
                        bind_we                = 1'b1;
                        bound_next[ch_idx]     = 1'b1;
                        slots_used_next        = slots_used_reg + CNT_W'(1);
                        result_next.action     = ACT_PWM;
                        result_next.pwm_slot   = 3'(new_slot);
                        result_next.newly_bound = 1'b1;
                        result_next.duty       = duty_lut[pct_c];
                    end
                    else
                    begin
                        // pool exhausted: fail safe on
                        result_next.action = ACT_LEVEL;
                        result_next.level  = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            bound_reg      <= '0;
            slots_used_reg <= '0;
            done_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            bound_reg      <= bound_next;
            slots_used_reg <= slots_used_next;
            done_reg       <= (state_reg == ST_EXEC);
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= cmd;
        end
        if (state_reg == ST_EXEC)
        begin
            result_reg <= result_next;
        end
    end

    `PSAR_ASSERT(a_slot_count_bound, clk, rst_n, slots_used_reg <= CNT_W'(NUM_PWM_SLOTS))
    `PSAR_ASSERT(a_done_not_busy, clk, rst_n, !(done && busy))
    `PSAR_IMPLIES(a_done_after_exec, clk, rst_n, done, $past(busy))
    `PSAR_IMPLIES(a_new_bind_is_pwm, clk, rst_n, done && result.newly_bound, result.action == ACT_PWM)

endmodule
